// File: rtl/core/overdrive_waveshaper_unit_defines.svh
// assertion macros for the overdrive waveshaper
`ifndef OVERDRIVE_WAVESHAPER_UNIT_DEFINES_SVH
`define OVERDRIVE_WAVESHAPER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define OWS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define OWS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define OWS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define OWS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// File: rtl/core/ows_pkg.sv
package ows_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int GAIN_BITS   = 16;
    localparam int GAIN_FRAC   = 8;
    localparam int X_SHIFT     = SAMPLE_BITS - GAIN_FRAC;
    localparam int PROD_BITS   = SAMPLE_BITS + GAIN_BITS + 1;
    localparam int X_BITS      = PROD_BITS - X_SHIFT;
    localparam int CFG_BITS    = 23;
    localparam int OUT_BITS    = 24;
    localparam int MODE_BITS   = 2;
    localparam int IDX_BITS    = 3;

    // cubic path
    localparam int AC_BITS     = 17;
    localparam int SQC_BITS    = 2 * AC_BITS;
    localparam int CUBE_BITS   = 3 * AC_BITS;
    localparam int CU_LSB      = 30;
    localparam int CU_BITS     = 16;
    localparam int QCP_BITS    = 32;
    localparam int QC_BITS     = 15;

    // symmetric path
    localparam int T_BITS      = X_BITS + 2;
    localparam int SQP_BITS    = 2 * T_BITS;
    localparam int SQS_BITS    = 2 * T_BITS - 2;
    localparam int T2_BITS     = SQS_BITS - 15;
    localparam int N_BITS      = T2_BITS + 1;
    localparam int LO_BITS     = 18;
    localparam int H_BITS      = T2_BITS - LO_BITS;
    localparam int QHP_BITS    = 37;
    localparam int QH_BITS     = 18;
    localparam int M_BITS      = LO_BITS + 2;
    localparam int QMP_BITS    = 2 * M_BITS;
    localparam int Q_BITS      = QH_BITS + LO_BITS;
    localparam int Y_BITS      = Q_BITS + 2;

    // divide by three through reciprocals
    localparam int RECIP3_S17  = 43691;
    localparam int RECIP3_S19  = 174763;
    localparam int RECIP3_S21  = 699051;

    localparam int ONE_Q15     = 32768;
    localparam int TWO_Q15     = 65536;
    localparam int THREE_Q15   = 98304;

    localparam int STAGES      = 9;

    localparam logic [GAIN_BITS-1:0] GAIN_RST      = 16'd256;
    localparam logic [CFG_BITS-1:0]  KNEE_LOW_RST  = 23'd10923;
    localparam logic [CFG_BITS-1:0]  KNEE_HIGH_RST = 23'd21845;
    localparam logic [CFG_BITS-1:0]  SYM_CEIL_RST  = 23'd32768;
    localparam logic [CFG_BITS-1:0]  SOFT_CEIL_RST = 23'd21845;
    localparam logic [CFG_BITS-1:0]  HARD_LIM_RST  = 23'd16384;
    localparam logic [CFG_BITS-1:0]  HARD_CEIL_RST = 23'd16384;

    typedef enum logic [MODE_BITS-1:0] {
        MODE_LINEAR = 2'd0,
        MODE_CUBIC  = 2'd1,
        MODE_SYM    = 2'd2,
        MODE_HARD   = 2'd3
    } ows_mode_t;

    typedef enum logic [IDX_BITS-1:0] {
        REG_DRIVE_GAIN    = 3'd0,
        REG_SHAPE_MODE    = 3'd1,
        REG_SYM_KNEE_LOW  = 3'd2,
        REG_SYM_KNEE_HIGH = 3'd3,
        REG_SYM_CEILING   = 3'd4,
        REG_SOFT_CEILING  = 3'd5,
        REG_HARD_LIMIT    = 3'd6,
        REG_HARD_CEILING  = 3'd7
    } ows_reg_t;

    typedef struct packed {
        logic x_neg;
        logic cub_neg;
        logic cub_pos;
        logic sym_low;
        logic sym_mid;
        logic hard_neg;
        logic hard_pos;
    } ows_flags_t;

endpackage

// File: rtl/core/ows_in_if.sv
interface ows_in_if;

    logic                                   valid;
    logic                                   ready;
    logic signed [ows_pkg::SAMPLE_BITS-1:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink (input valid, input sample_in, output ready);

endinterface

// File: rtl/core/ows_out_if.sv
interface ows_out_if;

    logic                                valid;
    logic                                ready;
    logic signed [ows_pkg::OUT_BITS-1:0] sample_out;
    logic                                overflowed;

    modport source (output valid, output sample_out, output overflowed, input ready);
    modport sink (input valid, input sample_out, input overflowed, output ready);

endinterface

// File: rtl/core/overdrive_waveshaper_unit.sv
// overdrive waveshaper: one signed audio sample in, one shaped sample out
//
// rx carries sample_in beats, tx carries sample_out and overflowed beats;
// a beat moves when valid and ready are both high
// the sample is scaled by the q8.8 drive gain and passed through the curve
// that shape_mode selects: linear, cubic soft clip, symmetric soft clip or
// hard clip; the result is saturated to 24 bits
// configuration is a plain write port (cfg_wr_en, cfg_index, cfg_data), to be
// written by the user only while no beat is in flight; the block does not enforce it
// an accepted beat moves through the stage registers in order, from p0_reg to
// out8_reg, and is shown on tx from out8_reg
// throughput: one beat per cycle, as every stage moves on each cycle that tx
// is not stalled; the nine stages, cut around the multipliers for the cube,
// the square and the division by three, set the latency
// when tx stalls with a beat pending, every stage holds and rx.ready drops;
// nothing is lost or repeated
// reset loads the register defaults and clears every valid bit; payload
// stages are not reset
`include "overdrive_waveshaper_unit_defines.svh"

module overdrive_waveshaper_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    ows_in_if.sink                          rx,
    ows_out_if.source                       tx,
    input  logic                            cfg_wr_en,
    input  logic [ows_pkg::IDX_BITS-1:0]    cfg_index,
    input  logic [ows_pkg::CFG_BITS-1:0]    cfg_data
);

    localparam int XB = ows_pkg::X_BITS;

    // configuration registers
    logic [ows_pkg::GAIN_BITS-1:0] drive_gain_reg;
    ows_pkg::ows_mode_t            shape_mode_reg;
    logic [ows_pkg::CFG_BITS-1:0]  sym_knee_low_reg;
    logic [ows_pkg::CFG_BITS-1:0]  sym_knee_high_reg;
    logic [ows_pkg::CFG_BITS-1:0]  sym_ceiling_reg;
    logic [ows_pkg::CFG_BITS-1:0]  soft_ceiling_reg;
    logic [ows_pkg::CFG_BITS-1:0]  hard_limit_reg;
    logic [ows_pkg::CFG_BITS-1:0]  hard_ceiling_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drive_gain_reg    <= ows_pkg::GAIN_RST;
            shape_mode_reg    <= ows_pkg::MODE_LINEAR;
            sym_knee_low_reg  <= ows_pkg::KNEE_LOW_RST;
            sym_knee_high_reg <= ows_pkg::KNEE_HIGH_RST;
            sym_ceiling_reg   <= ows_pkg::SYM_CEIL_RST;
            soft_ceiling_reg  <= ows_pkg::SOFT_CEIL_RST;
            hard_limit_reg    <= ows_pkg::HARD_LIM_RST;
            hard_ceiling_reg  <= ows_pkg::HARD_CEIL_RST;
        end
        else if (cfg_wr_en)
        begin
            case (ows_pkg::ows_reg_t'(cfg_index))
                ows_pkg::REG_DRIVE_GAIN:
                    drive_gain_reg <= cfg_data[ows_pkg::GAIN_BITS-1:0];
                ows_pkg::REG_SHAPE_MODE:
                    shape_mode_reg <= ows_pkg::ows_mode_t'(cfg_data[ows_pkg::MODE_BITS-1:0]);
                ows_pkg::REG_SYM_KNEE_LOW:  sym_knee_low_reg  <= cfg_data;
                ows_pkg::REG_SYM_KNEE_HIGH: sym_knee_high_reg <= cfg_data;
                ows_pkg::REG_SYM_CEILING:   sym_ceiling_reg   <= cfg_data;
                ows_pkg::REG_SOFT_CEILING:  soft_ceiling_reg  <= cfg_data;
                ows_pkg::REG_HARD_LIMIT:    hard_limit_reg    <= cfg_data;
                ows_pkg::REG_HARD_CEILING:  hard_ceiling_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // pipeline control
    logic [ows_pkg::STAGES-1:0] valid_reg;
    logic [ows_pkg::STAGES-1:0] valid_next;
    logic                       advance;

    assign advance    = !valid_reg[ows_pkg::STAGES-1] || tx.ready;
    assign rx.ready   = advance;
    assign tx.valid   = valid_reg[ows_pkg::STAGES-1];
    assign valid_next = {valid_reg[ows_pkg::STAGES-2:0], rx.valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (advance)
        begin
            valid_reg <= valid_next;
        end
    end

    // stage 0: gain product
    logic signed [ows_pkg::PROD_BITS-1:0] p0_reg;
    logic signed [ows_pkg::PROD_BITS-1:0] p0_next;

    assign p0_next = rx.sample_in * $signed({1'b0, drive_gain_reg});

    // stage 1: scaled sample, magnitude, region decisions
    logic signed [XB-1:0] x1_next;
    logic        [XB-1:0] ax1_next;
    logic signed [XB:0]   xe1;
    logic signed [XB:0]   lim1;
    ows_pkg::ows_flags_t  f1_next;
    logic signed [XB-1:0] x1_reg;
    logic        [XB-1:0] ax1_reg;
    ows_pkg::ows_flags_t  f1_reg;

    assign x1_next  = p0_reg[ows_pkg::PROD_BITS-1:ows_pkg::X_SHIFT];
    assign ax1_next = x1_next[XB-1] ? XB'(-x1_next) : XB'(x1_next);
    assign xe1      = (XB+1)'(x1_next);
    assign lim1     = $signed({{(XB+1-ows_pkg::CFG_BITS){1'b0}}, hard_limit_reg});

    always_comb
    begin
        f1_next.x_neg    = x1_next[XB-1];
        f1_next.cub_neg  = x1_next <= $signed(-XB'(ows_pkg::ONE_Q15));
        f1_next.cub_pos  = x1_next > $signed(XB'(ows_pkg::ONE_Q15));
        f1_next.sym_low  = ax1_next <= XB'(sym_knee_low_reg);
        f1_next.sym_mid  = ax1_next < XB'(sym_knee_high_reg);
        f1_next.hard_neg = xe1 <= -lim1;
        f1_next.hard_pos = xe1 >= lim1;
    end

    // stage 2: squares
    logic        [ows_pkg::AC_BITS-1:0]  ac2_next;
    logic        [ows_pkg::T_BITS-1:0]   ax3_2;
    logic signed [ows_pkg::T_BITS-1:0]   t2v;
    logic signed [ows_pkg::SQP_BITS-1:0] sqp2;
    logic        [ows_pkg::SQC_BITS-1:0] sqc2_next;
    logic        [ows_pkg::SQS_BITS-1:0] sqs2_next;
    logic signed [XB-1:0]                x2_reg;
    logic        [ows_pkg::AC_BITS-1:0]  ac2_reg;
    logic        [ows_pkg::SQC_BITS-1:0] sqc2_reg;
    logic        [ows_pkg::SQS_BITS-1:0] sqs2_reg;
    ows_pkg::ows_flags_t                 f2_reg;

    assign ac2_next  = ax1_reg[ows_pkg::AC_BITS-1:0];
    assign sqc2_next = ac2_next * ac2_next;
    assign ax3_2     = ows_pkg::T_BITS'({ax1_reg, 1'b0}) + ows_pkg::T_BITS'(ax1_reg);
    assign t2v       = $signed(ows_pkg::T_BITS'(ows_pkg::TWO_Q15) - ax3_2);
    assign sqp2      = t2v * t2v;
    assign sqs2_next = sqp2[ows_pkg::SQS_BITS-1:0];

    // stage 3: cube, symmetric numerator magnitude
    logic        [ows_pkg::CUBE_BITS-1:0] cube3_next;
    logic        [ows_pkg::T2_BITS-1:0]   tq3;
    logic signed [ows_pkg::N_BITS-1:0]    n3;
    logic signed [ows_pkg::N_BITS-1:0]    nneg3;
    logic        [ows_pkg::T2_BITS-1:0]   an3_next;
    logic signed [XB-1:0]                 x3_reg;
    logic        [ows_pkg::CUBE_BITS-1:0] cube3_reg;
    logic        [ows_pkg::T2_BITS-1:0]   an3_reg;
    logic                                 nn3_reg;
    ows_pkg::ows_flags_t                  f3_reg;

    assign cube3_next = sqc2_reg * ows_pkg::CUBE_BITS'(ac2_reg);
    assign tq3        = sqs2_reg[ows_pkg::SQS_BITS-1:15];
    assign n3         = $signed(ows_pkg::N_BITS'(ows_pkg::THREE_Q15))
                      - $signed({1'b0, tq3});
    assign nneg3      = -n3;
    assign an3_next   = n3[ows_pkg::N_BITS-1] ? nneg3[ows_pkg::T2_BITS-1:0]
                                              : n3[ows_pkg::T2_BITS-1:0];

    // stage 4: reciprocal products
    logic [ows_pkg::CU_BITS-1:0]  cu4;
    logic [ows_pkg::H_BITS-1:0]   h4_next;
    logic [ows_pkg::QCP_BITS-1:0] qcp4_next;
    logic [ows_pkg::QHP_BITS-1:0] qhp4_next;
    logic signed [XB-1:0]         x4_reg;
    logic [ows_pkg::QCP_BITS-1:0] qcp4_reg;
    logic [ows_pkg::QHP_BITS-1:0] qhp4_reg;
    logic [ows_pkg::H_BITS-1:0]   h4_reg;
    logic [ows_pkg::LO_BITS-1:0]  lo4_reg;
    logic                         nn4_reg;
    ows_pkg::ows_flags_t          f4_reg;

    assign cu4       = cube3_reg[ows_pkg::CU_LSB+ows_pkg::CU_BITS-1:ows_pkg::CU_LSB];
    assign qcp4_next = ows_pkg::QCP_BITS'(cu4) * ows_pkg::QCP_BITS'(ows_pkg::RECIP3_S17);
    assign h4_next   = an3_reg[ows_pkg::T2_BITS-1:ows_pkg::LO_BITS];
    assign qhp4_next = ows_pkg::QHP_BITS'(h4_next) * ows_pkg::QHP_BITS'(ows_pkg::RECIP3_S19);

    // stage 5: cubic result, high quotient and remainder
    logic        [ows_pkg::QC_BITS-1:0] qc5;
    logic signed [XB:0]                 qcs5;
    logic signed [XB:0]                 yc5_next;
    logic        [ows_pkg::QH_BITS-1:0] qh5_next;
    logic        [ows_pkg::H_BITS:0]    rh5;
    logic        [ows_pkg::M_BITS-1:0]  m5_next;
    logic signed [XB-1:0]               x5_reg;
    logic signed [XB:0]                 yc5_reg;
    logic        [ows_pkg::QH_BITS-1:0] qh5_reg;
    logic        [ows_pkg::M_BITS-1:0]  m5_reg;
    logic                               nn5_reg;
    ows_pkg::ows_flags_t                f5_reg;

    assign qc5      = qcp4_reg[ows_pkg::QCP_BITS-1:17];
    assign qcs5     = $signed({{(XB+1-ows_pkg::QC_BITS){1'b0}}, qc5});
    assign yc5_next = (XB+1)'(x4_reg) - (f4_reg.x_neg ? -qcs5 : qcs5);
    assign qh5_next = qhp4_reg[ows_pkg::QHP_BITS-1:19];
    assign rh5      = (ows_pkg::H_BITS+1)'(h4_reg)
                    - (ows_pkg::H_BITS+1)'({qh5_next, 1'b0})
                    - (ows_pkg::H_BITS+1)'(qh5_next);
    assign m5_next  = {rh5[1:0], lo4_reg};

    // stage 6: low quotient product
    logic        [ows_pkg::QMP_BITS-1:0] qmp6_next;
    logic signed [XB-1:0]                x6_reg;
    logic signed [XB:0]                  yc6_reg;
    logic        [ows_pkg::QH_BITS-1:0]  qh6_reg;
    logic        [ows_pkg::QMP_BITS-1:0] qmp6_reg;
    logic                                nn6_reg;
    ows_pkg::ows_flags_t                 f6_reg;

    assign qmp6_next = ows_pkg::QMP_BITS'(m5_reg) * ows_pkg::QMP_BITS'(ows_pkg::RECIP3_S21);

    // stage 7: curve selection
    logic        [ows_pkg::Q_BITS-1:0] q7;
    logic signed [ows_pkg::Y_BITS-1:0] qs7;
    logic signed [ows_pkg::Y_BITS-1:0] xs7;
    logic signed [ows_pkg::Y_BITS-1:0] ysym7;
    logic signed [ows_pkg::Y_BITS-1:0] y7_next;
    logic signed [ows_pkg::Y_BITS-1:0] y7_reg;
    logic signed [ows_pkg::Y_BITS-1:0] symc7;
    logic signed [ows_pkg::Y_BITS-1:0] softc7;
    logic signed [ows_pkg::Y_BITS-1:0] hardc7;
    ows_pkg::ows_mode_t                mode7_reg;

    assign q7     = {qh6_reg, qmp6_reg[ows_pkg::LO_BITS+20:21]};
    assign qs7    = $signed({2'b00, q7});
    assign xs7    = ows_pkg::Y_BITS'(x6_reg);
    assign symc7  = $signed(ows_pkg::Y_BITS'(sym_ceiling_reg));
    assign softc7 = $signed(ows_pkg::Y_BITS'(soft_ceiling_reg));
    assign hardc7 = $signed(ows_pkg::Y_BITS'(hard_ceiling_reg));

    always_comb
    begin
        if (f6_reg.sym_low)
        begin
            ysym7 = xs7 + xs7;
        end
        else if (f6_reg.sym_mid)
        begin
            ysym7 = (f6_reg.x_neg ^ nn6_reg) ? -qs7 : qs7;
        end
        else
        begin
            ysym7 = f6_reg.x_neg ? -symc7 : symc7;
        end
    end

    always_comb
    begin
        case (shape_mode_reg)
            ows_pkg::MODE_CUBIC:
            begin
                if (f6_reg.cub_neg)
                    y7_next = -softc7;
                else if (f6_reg.cub_pos)
                    y7_next = softc7;
                else
                    y7_next = ows_pkg::Y_BITS'(yc6_reg);
            end
            ows_pkg::MODE_SYM:
                y7_next = ysym7;
            ows_pkg::MODE_HARD:
            begin
                if (f6_reg.hard_neg)
                    y7_next = -hardc7;
                else if (f6_reg.hard_pos)
                    y7_next = hardc7;
                else
                    y7_next = xs7;
            end
            default:
                y7_next = xs7;
        endcase
    end

    // stage 8: saturation into the output register
    localparam logic signed [ows_pkg::Y_BITS-1:0] Y_MAX =
        ows_pkg::Y_BITS'({1'b0, {(ows_pkg::OUT_BITS-1){1'b1}}});
    localparam logic signed [ows_pkg::Y_BITS-1:0] Y_MIN = -Y_MAX - 1;

    logic signed [ows_pkg::OUT_BITS-1:0] out8_next;
    logic                                ovf8_next;
    logic signed [ows_pkg::OUT_BITS-1:0] out8_reg;
    logic                                ovf8_reg;

    always_comb
    begin
        if (y7_reg > Y_MAX)
        begin
            out8_next = Y_MAX[ows_pkg::OUT_BITS-1:0];
            ovf8_next = (mode7_reg == ows_pkg::MODE_LINEAR);
        end
        else if (y7_reg < Y_MIN)
        begin
            out8_next = Y_MIN[ows_pkg::OUT_BITS-1:0];
            ovf8_next = (mode7_reg == ows_pkg::MODE_LINEAR);
        end
        else
        begin
            out8_next = y7_reg[ows_pkg::OUT_BITS-1:0];
            ovf8_next = 1'b0;
        end
    end

    assign tx.sample_out = out8_reg;
    assign tx.overflowed = ovf8_reg;

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            p0_reg    <= p0_next;

            x1_reg    <= x1_next;
            ax1_reg   <= ax1_next;
            f1_reg    <= f1_next;

            x2_reg    <= x1_reg;
            ac2_reg   <= ac2_next;
            sqc2_reg  <= sqc2_next;
            sqs2_reg  <= sqs2_next;
            f2_reg    <= f1_reg;

            x3_reg    <= x2_reg;
            cube3_reg <= cube3_next;
            an3_reg   <= an3_next;
            nn3_reg   <= n3[ows_pkg::N_BITS-1];
            f3_reg    <= f2_reg;

            x4_reg    <= x3_reg;
            qcp4_reg  <= qcp4_next;
            qhp4_reg  <= qhp4_next;
            h4_reg    <= h4_next;
            lo4_reg   <= an3_reg[ows_pkg::LO_BITS-1:0];
            nn4_reg   <= nn3_reg;
            f4_reg    <= f3_reg;

            x5_reg    <= x4_reg;
            yc5_reg   <= yc5_next;
            qh5_reg   <= qh5_next;
            m5_reg    <= m5_next;
            nn5_reg   <= nn4_reg;
            f5_reg    <= f4_reg;

            x6_reg    <= x5_reg;
            yc6_reg   <= yc5_reg;
            qh6_reg   <= qh5_reg;
            qmp6_reg  <= qmp6_next;
            nn6_reg   <= nn5_reg;
            f6_reg    <= f5_reg;

            y7_reg    <= y7_next;
            mode7_reg <= shape_mode_reg;

            out8_reg  <= out8_next;
            ovf8_reg  <= ovf8_next;
        end
    end

    // checks
    `OWS_ASSERT_NXT(a_accept_enters, clk, rst_n, rx.valid && rx.ready, valid_reg[0], "accepted beat did not enter the pipeline")
    `OWS_ASSERT_NXT(a_stall_holds, clk, rst_n, tx.valid && !tx.ready, $stable(valid_reg), "pipeline moved during an output stall")
    `OWS_ASSERT_IMP(a_flag_linear_only, clk, rst_n, tx.valid && tx.overflowed, mode7_reg == ows_pkg::MODE_LINEAR, "overflow flag outside linear mode")
    `OWS_ASSERT_IMP(a_flag_saturated, clk, rst_n, tx.valid && tx.overflowed, (tx.sample_out == Y_MAX[ows_pkg::OUT_BITS-1:0]) || (tx.sample_out == Y_MIN[ows_pkg::OUT_BITS-1:0]), "overflow flag without saturated output")

endmodule
